// ===== rtl/core/pfbc_pkg.sv =====
// Shared types, codes and a helper function of the per-flow byte counter.
`default_nettype none

package pfbc_pkg;

   typedef struct packed {
      logic [40:0] ppv;
      logic [63:0] addrs;
   } flow_key_type;

   localparam int KEY_W     = $bits(flow_key_type);
   localparam int VALID_BIT = 40;

   localparam logic [1:0] ST_EXISTING = 2'd0;
   localparam logic [1:0] ST_NEW      = 2'd1;
   localparam logic [1:0] ST_IGNORED  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [6:0] RESET_REPORTED_BITS = 7'd29;
   localparam logic [6:0] MAX_REPORTED_BITS   = 7'd64;

   localparam logic [0:0] REG_REPORTED_BITS = 1'b0;

   function automatic logic [6:0] width_of(input logic [63:0] value);
      logic [6:0] w;
      w = 7'd1;
      for (int i = 1; i < 64; i++) begin
         if (value[i]) begin
            w = 7'(i + 1);
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/per_flow_byte_counter.sv =====
// Top level of the per-flow byte counter: flow table control, aggregates and ports.
//
// One request beat carries the parsed header of one packet; every request gives exactly
// one response beat. TCP and UDP packets are looked up by their five-tuple in a hashed
// table with linear probing, held in one synchronous RAM of TABLE_ENTRIES words.
// Other protocols return an ignored status with the aggregates unchanged.
// The block handles one packet at a time. A counted packet passes the home-slot
// pipeline (hash fold, reciprocal multiply, remainder), one RAM read per probe, the add
// of its length and the write back; the next request is taken once its response has
// moved to the output register. An ignored packet does not wait for the home slot and
// reads no RAM; a full table costs TABLE_ENTRIES probes before the drop response.
// After reset the block sweeps the RAM once, one word per cycle, and takes no request
// beat until the sweep is done; register writes are taken.
// The response sits in an output register; when the receiver stalls, the block still
// takes the next request and holds its result until the register is free.
// reported_counter_bits is at byte address 0; pwdata[6:0] above 64 is stored as 64.
`default_nettype none

module per_flow_byte_counter
   import pfbc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096,
   parameter int COUNTER_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ip_protocol,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [15:0] req_packet_length,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_flow_bytes,
   output logic [12:0]      rsp_flow_count,
   output logic [5:0]       rsp_widest_counter,
   output logic [17:0]      rsp_summed_widths,
   output logic [18:0]      rsp_fixed_memory_bits,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int OCC_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int WORD_W = KEY_W + COUNTER_BITS;
   localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SLOT  = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_ADD   = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]        clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        probe_ff, probe_in;
   logic                    hit_ff, hit_in;
   logic [COUNTER_BITS-1:0] old_ff, old_in;
   logic [6:0]              old_w_ff, old_w_in;
   logic [COUNTER_BITS-1:0] sum_ff, sum_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [31:0]             res_bytes_ff, res_bytes_in;
   logic [OCC_W-1:0]        occupied_ff, occupied_in;
   logic [6:0]              max_w_ff, max_w_in;
   logic [17:0]             width_sum_ff, width_sum_in;
   logic [6:0]              rcb_ff, rcb_in;

   flow_key_type            key_in, key_ff;
   logic [15:0]             len_ff;
   logic                    is_flow_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_bytes_ff, rsp_bytes_in;
   logic [12:0]             rsp_count_ff, rsp_count_in;
   logic [5:0]              rsp_widest_ff, rsp_widest_in;
   logic [17:0]             rsp_summed_ff, rsp_summed_in;
   logic [18:0]             rsp_fixed_ff, rsp_fixed_in;

   logic                    accept;
   logic                    slot_valid;
   logic [IDX_W-1:0]        slot;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [WORD_W-1:0]       mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;
   logic [WORD_W-1:0]       mem_rdata;
   flow_key_type            rd_key;
   logic [COUNTER_BITS-1:0] rd_total;
   logic                    rd_hit;
   logic                    rd_empty;
   logic [COUNTER_BITS:0]   sum_full;
   logic [6:0]              new_w;
   logic [63:0]             sum_ext;
   logic [31:0]             occ_ext;
   logic [6:0]              wr_value;
   logic                    csr_write;

   assign accept = req_valid && req_ready;

   always_comb begin
      key_in.addrs = {req_src_addr, req_dst_addr};
      key_in.ppv   = {1'b1, req_ip_protocol, req_src_port, req_dst_port};
   end

   pfbc_home_slot #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_home_slot (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .key        (key_in),
      .slot_valid (slot_valid),
      .slot       (slot)
   );

   pfbc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_flow_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      rd_key   = flow_key_type'(mem_rdata[WORD_W-1:COUNTER_BITS]);
      rd_total = mem_rdata[COUNTER_BITS-1:0];
      rd_empty = !rd_key.ppv[VALID_BIT];
      rd_hit   = rd_key.ppv[VALID_BIT] && (rd_key == key_ff);
      sum_full = {1'b0, old_ff} + (COUNTER_BITS + 1)'(len_ff);
      new_w    = width_of(64'(sum_ff));
      sum_ext  = 64'(sum_ff);
      occ_ext  = 32'(occupied_ff);
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      hit_in        = hit_ff;
      old_in        = old_ff;
      old_w_in      = old_w_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_bytes_in  = res_bytes_ff;
      occupied_in   = occupied_ff;
      max_w_in      = max_w_ff;
      width_sum_in  = width_sum_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = {key_ff, sum_ff};
      mem_raddr     = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_widest_in = rsp_widest_ff;
      rsp_summed_in = rsp_summed_ff;
      rsp_fixed_in  = rsp_fixed_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (!is_flow_ff) begin
               res_status_in = ST_IGNORED;
               res_bytes_in  = '0;
               state_in      = S_EMIT;
            end else if (slot_valid) begin
               mem_raddr = slot;
               idx_in    = slot;
               probe_in  = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (rd_hit || rd_empty) begin
               hit_in   = rd_hit;
               old_in   = rd_hit ? rd_total : '0;
               state_in = S_ADD;
            end else if (probe_ff == LAST_IDX) begin
               res_status_in = ST_FULL;
               res_bytes_in  = '0;
               state_in      = S_EMIT;
            end else begin
               idx_in    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               mem_raddr = idx_in;
               probe_in  = probe_ff + 1'b1;
            end
         end
         S_ADD: begin
            sum_in   = sum_full[COUNTER_BITS] ? CNT_MAX : sum_full[COUNTER_BITS-1:0];
            old_w_in = width_of(64'(old_ff));
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we       = 1'b1;
            width_sum_in = width_sum_ff - (hit_ff ? 18'(old_w_ff) : 18'd0) + 18'(new_w);
            if (new_w > max_w_ff) begin
               max_w_in = new_w;
            end
            if (!hit_ff) begin
               occupied_in = occupied_ff + 1'b1;
            end
            res_status_in = hit_ff ? ST_EXISTING : ST_NEW;
            res_bytes_in  = sum_ext[31:0];
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bytes_in  = res_bytes_ff;
               rsp_count_in  = occ_ext[12:0];
               rsp_widest_in = max_w_ff[5:0];
               rsp_summed_in = width_sum_ff;
               rsp_fixed_in  = occ_ext[18:0] * 19'(rcb_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_REPORTED_BITS);
   assign wr_value  = pwdata[6:0];

   always_comb begin
      rcb_in = rcb_ff;
      if (csr_write) begin
         rcb_in = (wr_value > MAX_REPORTED_BITS) ? MAX_REPORTED_BITS : wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         occupied_ff  <= '0;
         max_w_ff     <= '0;
         width_sum_ff <= '0;
         rcb_ff       <= RESET_REPORTED_BITS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         occupied_ff  <= occupied_in;
         max_w_ff     <= max_w_in;
         width_sum_ff <= width_sum_in;
         rcb_ff       <= rcb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff     <= key_in;
         len_ff     <= req_packet_length;
         is_flow_ff <= (req_ip_protocol == PROTO_TCP) || (req_ip_protocol == PROTO_UDP);
      end
      idx_ff        <= idx_in;
      probe_ff      <= probe_in;
      hit_ff        <= hit_in;
      old_ff        <= old_in;
      old_w_ff      <= old_w_in;
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_bytes_ff  <= res_bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_widest_ff <= rsp_widest_in;
      rsp_summed_ff <= rsp_summed_in;
      rsp_fixed_ff  <= rsp_fixed_in;
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_flow_bytes        = rsp_bytes_ff;
   assign rsp_flow_count        = rsp_count_ff;
   assign rsp_widest_counter    = rsp_widest_ff;
   assign rsp_summed_widths     = rsp_summed_ff;
   assign rsp_fixed_memory_bits = rsp_fixed_ff;

   assign prdata = (paddr[2] == REG_REPORTED_BITS) ? 32'(rcb_ff) : 32'd0;
   assign pready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/pfbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module pfbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data <= mem_array[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/pfbc_home_slot.sv =====
// Three-stage pipeline that folds a flow key and reduces it to its home slot.
`default_nettype none

module pfbc_home_slot
   import pfbc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire flow_key_type                     key,
   output logic                                  slot_valid,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      slot
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

   logic [2:0]       valid_ff;
   logic [2:0]       valid_in;
   logic [63:0]      mixed;
   logic [15:0]      fold_in;
   logic [15:0]      fold_ff;
   logic [15:0]      fold2_ff;
   logic [48:0]      product;
   logic [15:0]      quot_in;
   logic [15:0]      quot_ff;
   logic [31:0]      remainder;
   logic [IDX_W-1:0] slot_in;
   logic [IDX_W-1:0] slot_ff;

   always_comb begin
      mixed     = key.addrs ^ 64'(key.ppv);
      fold_in   = mixed[15:0] ^ mixed[31:16] ^ mixed[47:32] ^ mixed[63:48];
      product   = 49'(fold_ff) * 49'(RECIP);
      quot_in   = product[47:32];
      remainder = 32'(fold2_ff) - 32'(quot_ff) * 32'(TABLE_ENTRIES);
      slot_in   = remainder[IDX_W-1:0];
      valid_in  = {valid_ff[1:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff  <= fold_in;
      fold2_ff <= fold_ff;
      quot_ff  <= quot_in;
      slot_ff  <= slot_in;
   end

   assign slot_valid = valid_ff[2];
   assign slot       = slot_ff;

endmodule

`default_nettype wire

// ===== test/per_flow_byte_counter_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the per-flow byte counter: directed and random traffic.
module per_flow_byte_counter_test
   import pfbc_pkg::*;
();

   localparam int FLOW_SLOTS      = 4096;
   localparam int RANDOM_PACKETS  = 1400;
   localparam int BURST_PACKETS   = 200;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int MAX_REPORTS     = 10;
   localparam int IDLE_PERCENT    = 36;
   localparam logic [2:0] REPORTED_BITS_ADDR = 3'(4 * REG_REPORTED_BITS);

   typedef struct packed {
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] len;
   } header_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] bytes;
      logic [12:0] flows;
      logic [5:0]  widest;
      logic [17:0] summed;
      logic [18:0] fixed_bits;
   } flow_report_type;

   typedef struct packed {
      header_beat_type hdr;
      logic            typed;
      flow_report_type report;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ip_protocol = '0;
   logic [31:0] req_src_addr = '0;
   logic [31:0] req_dst_addr = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [15:0] req_packet_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_flow_bytes;
   logic [12:0] rsp_flow_count;
   logic [5:0]  rsp_widest_counter;
   logic [17:0] rsp_summed_widths;
   logic [18:0] rsp_fixed_memory_bits;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bit [63:0] slot_addrs [FLOW_SLOTS];
   bit [40:0] slot_ppv [FLOW_SLOTS];
   bit [31:0] slot_total [FLOW_SLOTS];
   int flows_held = 0;
   int widest_seen = 0;
   int width_sum = 0;
   int reported_bits = int'(RESET_REPORTED_BITS);

   flow_report_type expected_reports [$];
   header_beat_type flow_pool [$];
   directed_row_type directed_rows [$];
   int failures = 0;
   int rsp_beats = 0;
   int idle_pct = IDLE_PERCENT;
   int quiet_cycles = 0;
   bit rsp_hold_request = 1'b0;

   per_flow_byte_counter dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_ip_protocol       (req_ip_protocol),
      .req_src_addr          (req_src_addr),
      .req_dst_addr          (req_dst_addr),
      .req_src_port          (req_src_port),
      .req_dst_port          (req_dst_port),
      .req_packet_length     (req_packet_length),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_flow_bytes        (rsp_flow_bytes),
      .rsp_flow_count        (rsp_flow_count),
      .rsp_widest_counter    (rsp_widest_counter),
      .rsp_summed_widths     (rsp_summed_widths),
      .rsp_fixed_memory_bits (rsp_fixed_memory_bits),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int bits_needed(input logic [31:0] value);
      int w;
      w = 1;
      for (int i = 1; i < 32; i++) begin
         if (value[i]) begin
            w = i + 1;
         end
      end
      return w;
   endfunction

   function automatic flow_report_type predict_report(input header_beat_type hdr);
      flow_report_type rep;
      flow_key_type key;
      logic [63:0] mixed;
      logic [31:0] folded;
      logic [31:0] old_total;
      logic [31:0] new_total;
      logic [32:0] sum;
      int idx;
      int w;
      bit hit;
      bit vacant;
      rep = '0;
      rep.status = ST_IGNORED;
      if (hdr.proto == PROTO_TCP || hdr.proto == PROTO_UDP) begin
         key.addrs = {hdr.src, hdr.dst};
         key.ppv = {1'b1, hdr.proto, hdr.sport, hdr.dport};
         mixed = key.addrs ^ 64'(key.ppv);
         mixed = mixed ^ (mixed >> 32);
         folded = mixed[31:0];
         folded = folded ^ (folded >> 16);
         idx = int'(folded[15:0]) % FLOW_SLOTS;
         hit = 1'b0;
         vacant = 1'b0;
         for (int n = 0; n < FLOW_SLOTS; n++) begin
            if (!slot_ppv[idx][VALID_BIT]) begin
               vacant = 1'b1;
               break;
            end
            if (slot_ppv[idx] == key.ppv && slot_addrs[idx] == key.addrs) begin
               hit = 1'b1;
               break;
            end
            idx = (idx + 1) % FLOW_SLOTS;
         end
         if (hit || vacant) begin
            old_total = hit ? slot_total[idx] : 32'd0;
            sum = {1'b0, old_total} + 33'(hdr.len);
            new_total = sum[32] ? '1 : sum[31:0];
            if (hit) begin
               width_sum -= bits_needed(old_total);
               rep.status = ST_EXISTING;
            end else begin
               slot_addrs[idx] = key.addrs;
               slot_ppv[idx] = key.ppv;
               flows_held++;
               rep.status = ST_NEW;
            end
            slot_total[idx] = new_total;
            w = bits_needed(new_total);
            width_sum += w;
            if (w > widest_seen) begin
               widest_seen = w;
            end
            rep.bytes = new_total;
         end else begin
            rep.status = ST_FULL;
         end
      end
      rep.flows = 13'(flows_held);
      rep.widest = 6'(widest_seen);
      rep.summed = 18'(width_sum);
      rep.fixed_bits = 19'(flows_held * reported_bits);
      return rep;
   endfunction

   function automatic directed_row_type stim_row(input logic [7:0] proto,
                                                 input logic [31:0] src,
                                                 input logic [31:0] dst,
                                                 input logic [15:0] sport,
                                                 input logic [15:0] dport,
                                                 input logic [15:0] len,
                                                 input logic typed, input logic [1:0] status,
                                                 input logic [31:0] bytes, input int flows,
                                                 input int widest, input int summed,
                                                 input int fixed_bits);
      directed_row_type row;
      row.hdr = {proto, src, dst, sport, dport, len};
      row.typed = typed;
      row.report = {status, bytes, 13'(flows), 6'(widest), 18'(summed), 19'(fixed_bits)};
      return row;
   endfunction

   function automatic logic [15:0] random_length();
      return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 1500));
   endfunction

   function automatic header_beat_type fresh_flow();
      header_beat_type hdr;
      hdr.proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      hdr.src = $urandom;
      hdr.dst = $urandom;
      hdr.sport = 16'($urandom);
      hdr.dport = 16'($urandom);
      hdr.len = random_length();
      return hdr;
   endfunction

   function automatic header_beat_type revisit_flow();
      header_beat_type hdr;
      hdr = flow_pool[$urandom_range(flow_pool.size() - 1)];
      hdr.len = random_length();
      return hdr;
   endfunction

   task automatic send_header(input header_beat_type hdr, input logic use_typed,
                              input flow_report_type typed_report);
      flow_report_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ip_protocol <= hdr.proto;
      req_src_addr <= hdr.src;
      req_dst_addr <= hdr.dst;
      req_src_port <= hdr.sport;
      req_dst_port <= hdr.dport;
      req_packet_length <= hdr.len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_report(hdr);
      expected_reports.push_back(use_typed ? typed_report : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reported_bits(input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REPORTED_BITS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      reported_bits = (value[6:0] > MAX_REPORTED_BITS) ? int'(MAX_REPORTED_BITS)
                                                        : int'(value[6:0]);
      @(posedge clock);
   endtask

   task automatic check_reported_bits();
      logic [31:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= REPORTED_BITS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== 32'(reported_bits)) begin
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("reported_counter_bits readback: expected %0d, got %0d",
                     reported_bits, readback);
         end
      end
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] value);
      write_reported_bits(value);
      check_reported_bits();
   endtask

   task automatic run_random_traffic(input int packet_target);
      header_beat_type hdr;
      logic [31:0] mask;
      int sent;
      int pick;
      sent = 0;
      while (sent < packet_target) begin
         pick = $urandom_range(99);
         if (pick < 55 && flow_pool.size() != 0) begin
            hdr = revisit_flow();
         end else if (pick < 70 || flow_pool.size() == 0) begin
            hdr = fresh_flow();
            flow_pool.push_back(hdr);
         end else if (pick < 82) begin
            // Flipping the same bits in both addresses keeps the home slot, forcing a probe.
            hdr = revisit_flow();
            mask = $urandom;
            hdr.src ^= mask;
            hdr.dst ^= mask;
            flow_pool.push_back(hdr);
         end else begin
            hdr = {8'($urandom), 32'($urandom), 32'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom)};
         end
         sent++;
         send_header(hdr, 1'b0, '0);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      flow_report_type observed;
      flow_report_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         observed = {rsp_status, rsp_flow_bytes, rsp_flow_count, rsp_widest_counter,
                     rsp_summed_widths, rsp_fixed_memory_bits};
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("response beat %0d arrived with nothing outstanding", rsp_beats);
            end
         end else begin
            wanted = expected_reports.pop_front();
            if (observed !== wanted) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("response beat %0d mismatch", rsp_beats);
                  $display("  expected st=%0d bytes=%0d flows=%0d widest=%0d summed=%0d fixed=%0d",
                           wanted.status, wanted.bytes, wanted.flows, wanted.widest,
                           wanted.summed, wanted.fixed_bits);
                  $display("  actual   st=%0d bytes=%0d flows=%0d widest=%0d summed=%0d fixed=%0d",
                           observed.status, observed.bytes, observed.flows, observed.widest,
                           observed.summed, observed.fixed_bits);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      header_beat_type hdr;
      directed_rows.push_back(stim_row(8'd0, '0, '0, '0, '0, '0,
                                       1'b1, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'hFF, '1, '1, '1, '1, '1,
                                       1'b1, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_TCP, '0, '0, '0, '0, '0,
                                       1'b1, ST_NEW, 0, 1, 1, 1, 29));
      directed_rows.push_back(stim_row(PROTO_UDP, '1, '1, '1, '1, '1,
                                       1'b1, ST_NEW, 65535, 2, 16, 17, 58));
      directed_rows.push_back(stim_row(PROTO_UDP, '1, '1, '1, '1, '1,
                                       1'b1, ST_EXISTING, 131070, 2, 17, 18, 58));
      directed_rows.push_back(stim_row(PROTO_TCP, '0, '0, '0, '0, 16'd1,
                                       1'b1, ST_EXISTING, 1, 2, 17, 18, 58));
      directed_rows.push_back(stim_row(PROTO_TCP, '0, '0, '0, '0, '0,
                                       1'b0, ST_EXISTING, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'd5, 32'h1234_5678, 32'h9ABC_DEF0, 16'd80, 16'd443,
                                       16'd60, 1'b0, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'd7, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2,
                                       16'd100, 1'b0, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'd16, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2,
                                       16'd100, 1'b0, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'd18, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2,
                                       16'd100, 1'b0, ST_IGNORED, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_TCP, '1, '1, '1, '1, 16'h8000,
                                       1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, '0, '0, '0, '0, 16'd1,
                                       1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0001, 16'd1234,
                                       16'd80, 16'd1500, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'hC057_00FE, 32'h0AFF_00FE, 16'd1234,
                                       16'd80, 16'd40, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'hCFA7_0F0E, 32'h050F_0F0E, 16'd1234,
                                       16'd80, 16'd52, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'hC057_00FE, 32'h0AFF_00FE, 16'd1234,
                                       16'd80, 16'd64, 1'b0, ST_EXISTING, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'hCFA7_0F0E, 32'h050F_0F0E, 16'd1234,
                                       16'd80, 16'hFFFF, 1'b0, ST_EXISTING, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_TCP, 32'h8000_0000, 32'h0000_0001, 16'hFFFF,
                                       16'h0000, 16'd0, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_TCP, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 16'h0000,
                                       16'hFFFF, 16'hAAAA, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(PROTO_UDP, 32'h5555_5555, 32'h5555_5555, 16'h5555,
                                       16'hAAAA, 16'h5555, 1'b0, ST_NEW, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(8'h80, 32'h0102_0304, 32'h0506_0708, 16'd53, 16'd53,
                                       16'd512, 1'b0, ST_IGNORED, 0, 0, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_reported_bits();
      foreach (directed_rows[i]) begin
         send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].report);
      end
      settle();

      configure(32'd1);
      rsp_hold_request = 1'b1;
      run_random_traffic(RANDOM_PACKETS / 3);
      settle();
      configure($urandom);
      run_random_traffic(RANDOM_PACKETS / 3);
      settle();
      configure(32'd0);
      run_random_traffic(RANDOM_PACKETS - 2 * (RANDOM_PACKETS / 3));
      settle();

      // Known flows sent back to back, with neither side idling.
      configure(32'hFFFF_FF85);
      idle_pct = 0;
      repeat (BURST_PACKETS) send_header(revisit_flow(), 1'b0, '0);
      idle_pct = IDLE_PERCENT;
      settle();

      configure(32'(MAX_REPORTED_BITS));
      repeat (3) send_header(fresh_flow(), 1'b0, '0);
      repeat (12) send_header(revisit_flow(), 1'b0, '0);
      hdr = fresh_flow();
      hdr.proto = 8'd1;
      send_header(hdr, 1'b0, '0);
      settle();

      configure(32'hFFFF_FFC7);
      repeat (8) send_header(revisit_flow(), 1'b0, '0);
      send_header(fresh_flow(), 1'b0, '0);
      settle();

      repeat (20) @(posedge clock);
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pfbc_pkg.sv
rtl/core/pfbc_ram.sv
rtl/core/pfbc_home_slot.sv
rtl/core/per_flow_byte_counter.sv
test/per_flow_byte_counter_test.sv
